// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
// Both macros take a label, the clock, the reset, a trigger and a check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst, trig, chk) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (chk)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, trig, chk) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (chk)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, trig, chk)
`define ASSERT_NEXT(label, clk, rst, trig, chk)
`endif
`endif

// File: rtl/core/mfsl_pkg.sv
package mfsl_pkg;

  // Default width of the stream position counter
  localparam int OFFSET_WIDTH_DEF = 32;

  // Parser phases
  typedef enum logic [2:0] {
    PH_FIRST     = 3'd0,
    PH_ID3_HDR   = 3'd1,
    PH_ID3_SKIP  = 3'd2,
    PH_AFTER_ID3 = 3'd3,
    PH_AID_HDR   = 3'd4,
    PH_AID_SKIP  = 3'd5,
    PH_SEARCH    = 3'd6,
    PH_DONE      = 3'd7
  } phase_t;

  // Result status codes
  localparam logic [1:0] ST_FOUND   = 2'd0;
  localparam logic [1:0] ST_TAG_END = 2'd1;
  localparam logic [1:0] ST_NO_SYNC = 2'd2;

  // Tag signatures
  localparam logic [23:0] ID3_MAGIC = 24'h494433;
  localparam logic [31:0] AID_MAGIC = 32'h41494401;

  // Registered input beat handed to the parser
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       eos;
  } step_t;

endpackage

// File: rtl/core/mfsl_in_if.sv
interface mfsl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, data_byte, end_of_stream, input ready);
  modport sink (input valid, data_byte, end_of_stream, output ready);
endinterface

// File: rtl/core/mfsl_out_if.sv
interface mfsl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] frame_offset;
  logic [31:0] header_word;

  modport source (output valid, status, frame_offset, header_word, input ready);
  modport sink (input valid, status, frame_offset, header_word, output ready);
endinterface

// File: rtl/core/mfsl_hdr_check.sv
module mfsl_hdr_check
  import mfsl_pkg::*;
(
  input  logic [31:0] word,
  output logic        ok
);

  // Forbidden channel modes per bitrate index for MPEG-1 layer II
  localparam logic [3:0] MODE_FORBID [16] = '{
    4'd0, 4'd7, 4'd7, 4'd7, 4'd0, 4'd7, 4'd0, 4'd0,
    4'd0, 4'd0, 4'd0, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8
  };

  logic [7:0] b0, b1, b2, b3;
  logic [3:0] forbid;
  logic       mode_bad;

  assign b0 = word[31:24];
  assign b1 = word[23:16];
  assign b2 = word[15:8];
  assign b3 = word[7:0];

  // Check the bitrate/mode combination
  assign forbid   = MODE_FORBID[b2[7:4]];
  assign mode_bad = (b1[4:3] == 2'b11) && (b1[2:1] == 2'b10) && forbid[b3[7:6]];

  // Apply every header field rule
  assign ok = (b0 == 8'hFF) &&
              (b1[7:5] == 3'b111) &&
              (b1[4:3] != 2'b01) &&
              (b1[2:1] != 2'b00) &&
              (b2[7:4] != 4'hF) &&
              (b2[3:2] != 2'b11) &&
              !mode_bad &&
              (b3[1:0] != 2'b10);

endmodule

// File: rtl/core/mfsl_parser.sv
`include "assert_macros.svh"

module mfsl_parser
  import mfsl_pkg::*;
#(
  parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  step_t             cur,
  output logic              take,
  mfsl_out_if.source        result
);

  phase_t                   phase, phase_next;
  logic [31:0]              window, window_next;
  logic [2:0]               gather_count, gather_count_next;
  logic [27:0]              skip_remaining, skip_remaining_next;
  logic [OFFSET_WIDTH-1:0]  byte_position;
  logic [OFFSET_WIDTH-1:0]  offset;
  logic [OFFSET_WIDTH+31:0] offset_ext;
  logic [2:0]               gc_inc;
  logic [27:0]              skip_dec;
  logic [27:0]              id3_len, aid_len;
  logic                     hdr_ok, found, emit, restart;
  logic [1:0]               status_next;
  logic                     in_skip;

  logic                     out_valid;
  logic [1:0]               out_status;
  logic [31:0]              out_offset;
  logic [31:0]              out_header;

  // Advance when the result register can take whatever this beat yields
  assign take = cur.valid && (!out_valid || result.ready);

  mfsl_hdr_check u_hdr (
    .word (window_next),
    .ok   (hdr_ok)
  );

  // Shift in the new byte and count it
  always_comb begin
    window_next = (phase != PH_DONE) ? {window[23:0], cur.data} : window;
    gc_inc      = (phase != PH_DONE && gather_count < 3'd6) ? gather_count + 3'd1
                                                            : gather_count;
  end

  assign id3_len  = {window_next[30:24], window_next[22:16], window_next[14:8],
                     window_next[6:0]};
  assign aid_len  = {12'd0, window_next[7:0], window_next[15:8]};
  assign skip_dec = (skip_remaining != 28'd0) ? skip_remaining - 28'd1 : skip_remaining;

  // Offset of the first header byte, kept to 32 bits
  assign offset     = byte_position - OFFSET_WIDTH'(3);
  assign offset_ext = {32'd0, offset};

  // Phase sequencing and result selection
  always_comb begin
    phase_next          = phase;
    gather_count_next   = gc_inc;
    skip_remaining_next = skip_remaining;
    found               = 1'b0;
    unique case (phase)
      PH_FIRST, PH_AFTER_ID3: begin
        if (gc_inc >= 3'd4) begin
          priority if (phase == PH_FIRST && window_next[31:8] == ID3_MAGIC) begin
            phase_next        = PH_ID3_HDR;
            gather_count_next = 3'd0;
          end else if (window_next == AID_MAGIC) begin
            phase_next        = PH_AID_HDR;
            gather_count_next = 3'd0;
          end else if (hdr_ok) begin
            found = 1'b1;
          end else begin
            phase_next = PH_SEARCH;
          end
        end
      end
      PH_ID3_HDR: begin
        if (gc_inc >= 3'd6) begin
          gather_count_next   = 3'd0;
          skip_remaining_next = id3_len;
          phase_next          = (id3_len == 28'd0) ? PH_AFTER_ID3 : PH_ID3_SKIP;
        end
      end
      PH_AID_HDR: begin
        if (gc_inc >= 3'd2) begin
          gather_count_next   = 3'd0;
          skip_remaining_next = aid_len;
          phase_next          = (aid_len == 28'd0) ? PH_SEARCH : PH_AID_SKIP;
        end
      end
      PH_ID3_SKIP, PH_AID_SKIP: begin
        skip_remaining_next = skip_dec;
        if (skip_dec == 28'd0) begin
          gather_count_next = 3'd0;
          phase_next        = (phase == PH_ID3_SKIP) ? PH_AFTER_ID3 : PH_SEARCH;
        end
      end
      PH_SEARCH: begin
        if (gc_inc > 3'd4) gather_count_next = 3'd4;
        found = (gc_inc >= 3'd4) && hdr_ok;
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase

    if (found && !cur.eos) phase_next = PH_DONE;

    // A marked last byte reports unless the header was already reported
    emit    = found || (cur.eos && phase != PH_DONE);
    restart = cur.eos;
    priority if (found) begin
      status_next = ST_FOUND;
    end else if (phase == PH_ID3_HDR || phase == PH_ID3_SKIP || phase == PH_AID_HDR ||
                 phase == PH_AID_SKIP || phase_next == PH_ID3_HDR ||
                 phase_next == PH_ID3_SKIP || phase_next == PH_AID_HDR ||
                 phase_next == PH_AID_SKIP) begin
      status_next = ST_TAG_END;
    end else begin
      status_next = ST_NO_SYNC;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_FIRST;
      window         <= 32'd0;
      gather_count   <= 3'd0;
      skip_remaining <= 28'd0;
      byte_position  <= '0;
    end else if (take) begin
      if (restart) begin
        phase          <= PH_FIRST;
        window         <= 32'd0;
        gather_count   <= 3'd0;
        skip_remaining <= 28'd0;
        byte_position  <= '0;
      end else begin
        phase          <= phase_next;
        window         <= window_next;
        gather_count   <= gather_count_next;
        skip_remaining <= skip_remaining_next;
        byte_position  <= byte_position + OFFSET_WIDTH'(1);
      end
    end
  end

  // Result register: hold until the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_status <= status_next;
      out_offset <= found ? offset_ext[31:0] : 32'd0;
      out_header <= found ? window_next : 32'd0;
    end
  end

  assign result.valid        = out_valid;
  assign result.status       = out_status;
  assign result.frame_offset = out_offset;
  assign result.header_word  = out_header;

  assign in_skip = (phase == PH_ID3_SKIP) || (phase == PH_AID_SKIP);

  `ASSERT_IMPLIES(a_gather_sat, clk, rst, 1'b1, gather_count <= 3'd6)
  `ASSERT_IMPLIES(a_skip_live, clk, rst, in_skip, skip_remaining != 28'd0)
  `ASSERT_NEXT(a_eos_restart, clk, rst, take && cur.eos, phase == PH_FIRST && byte_position == '0)
  `ASSERT_NEXT(a_found_result, clk, rst, take && found, out_valid && out_status == ST_FOUND)
  `ASSERT_NEXT(a_done_hold, clk, rst, take && phase == PH_DONE && !cur.eos, phase == PH_DONE)

endmodule

// File: rtl/core/mp3_frame_start_locator.sv
// A byte passes the input register and then the result register before its result can be taken.
// Throughput: one byte per cycle; a held result beat stalls the input until it is taken.
// The header check and phase update fit between the input and the result register.
// Reset (rst, synchronous, active high) clears the parser to gathering the first bytes
// at offset zero and empties both registers.
module mp3_frame_start_locator
  import mfsl_pkg::*;
#(
  parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst,
  mfsl_in_if.sink    stream,
  mfsl_out_if.source result
);

  step_t cur;
  logic  take;

  // Input register: refill when empty or whenever the held byte moves on
  assign stream.ready = !cur.valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (stream.ready) begin
      cur.valid <= stream.valid;
    end
    if (stream.ready && stream.valid) begin
      cur.data <= stream.data_byte;
      cur.eos  <= stream.end_of_stream;
    end
  end

  mfsl_parser #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .cur    (cur),
    .take   (take),
    .result (result)
  );

endmodule
